/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain property, sampled on the rising edge, off in reset.
`define RPN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rpn check failed");

// Next-cycle implication.
`define RPN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rpn check failed");

`endif

/* rtl/rpn_pkg.sv */
// Types, codes and arithmetic helpers of the RPN calculator.
package rpn_pkg;

  localparam int VW          = 48;
  localparam int MAX_RESULTS = 32;

  localparam logic [3:0] OP_PUSH  = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_MOD   = 4'd5;
  localparam logic [3:0] OP_PEEK  = 4'd6;
  localparam logic [3:0] OP_POP   = 4'd7;
  localparam logic [3:0] OP_DUMP  = 4'd8;
  localparam logic [3:0] OP_CLEAR = 4'd9;
  localparam logic [3:0] OP_DUP   = 4'd10;
  localparam logic [3:0] OP_SWAP  = 4'd11;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_UNF = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;
  localparam logic [1:0] ST_DBZ = 2'd3;

  // read address select
  localparam logic [1:0] RD_TOP    = 2'd0;
  localparam logic [1:0] RD_SECOND = 2'd1;
  localparam logic [1:0] RD_WALK   = 2'd2;

  // write address select
  localparam logic [1:0] WA_CNT    = 2'd0;
  localparam logic [1:0] WA_TOP    = 2'd1;
  localparam logic [1:0] WA_SECOND = 2'd2;

  // write data select
  localparam logic [2:0] WD_IN  = 3'd0;
  localparam logic [2:0] WD_RD  = 3'd1;
  localparam logic [2:0] WD_A   = 3'd2;
  localparam logic [2:0] WD_B   = 3'd3;
  localparam logic [2:0] WD_RES = 3'd4;

  typedef struct packed {
    logic [3:0]             op;
    logic signed [VW-1:0]   operand;
  } rpn_in_t;

  typedef struct packed {
    logic signed [VW-1:0]   result_value;
    logic                   has_value;
    logic [1:0]             status;
    logic                   last;
  } rpn_out_t;

  typedef struct packed {
    logic       load_in;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_addr_sel;
    logic [2:0] wr_data_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       load_a;
    logic       load_b;
    logic       alu_start;
    logic       mul_step;
    logic       div_step;
    logic       res_load;
    logic       walk_init;
    logic       walk_step;
    logic       out_load;
    logic       out_from_rd;
    logic       out_last;
    logic [1:0] out_status;
  } rpn_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       cnt_zero;
    logic       cnt_lt2;
    logic       cnt_full;
    logic       a_zero;
    logic       mul_done;
    logic       div_done;
    logic       walk_last;
    logic       slot_free;
  } rpn_stat_t;

  function automatic logic [VW-1:0] mag48(input logic [VW-1:0] v);
    return v[VW-1] ? (~v + VW'(1)) : v;
  endfunction

  // Signed result from sign and magnitude, saturated to 48 bits.
  function automatic logic [VW-1:0] sat_mag(input logic neg, input logic [79:0] m);
    logic big;
    logic [VW-1:0] lo;
    big = (m[79:VW-1] != '0);
    lo  = m[VW-1:0];
    if (big) return neg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    return neg ? (~lo + VW'(1)) : lo;
  endfunction

  // Saturate a 49-bit sum to 48 bits.
  function automatic logic [VW-1:0] sat49(input logic [VW:0] s);
    if (s[VW] != s[VW-1]) return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    return s[VW-1:0];
  endfunction

endpackage

/* rtl/rpn_ctrl.sv */
// Sequencer of the RPN calculator: decodes a token and steps the datapath.
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpn_pkg::rpn_stat_t stat,
  output rpn_pkg::rpn_cmd_t  cmd
);
  import rpn_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RDA    = 4'd2;
  localparam logic [3:0] S_RDB    = 4'd3;
  localparam logic [3:0] S_SWP1   = 4'd4;
  localparam logic [3:0] S_SWP2   = 4'd5;
  localparam logic [3:0] S_EXEC   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_WB     = 4'd10;
  localparam logic [3:0] S_PEEK   = 4'd11;
  localparam logic [3:0] S_DUPR   = 4'd12;
  localparam logic [3:0] S_DUMPW  = 4'd13;
  localparam logic [3:0] S_DUMPE  = 4'd14;
  localparam logic [3:0] S_EMIT   = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [1:0] code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    code_nxt  = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        code_nxt  = ST_OK;
        state_nxt = S_EMIT;
        unique case (stat.op) inside
          OP_PUSH: begin
            if (stat.cnt_full) begin
              code_nxt = ST_OVF;
            end else begin
              cmd.wr_en       = 1'b1;
              cmd.wr_addr_sel = WA_CNT;
              cmd.wr_data_sel = WD_IN;
              cmd.cnt_inc     = 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SWAP: begin
            if (stat.cnt_lt2) begin
              code_nxt = ST_UNF;
            end else begin
              cmd.rd_sel = RD_TOP;
              state_nxt  = S_RDA;
            end
          end
          OP_PEEK, OP_POP: begin
            if (stat.cnt_zero) begin
              code_nxt = ST_UNF;
            end else begin
              cmd.rd_sel = RD_TOP;
              state_nxt  = S_PEEK;
            end
          end
          OP_DUMP: begin
            if (stat.cnt_zero) begin
              code_nxt = ST_UNF;
            end else begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_DUMPW;
            end
          end
          OP_CLEAR: begin
            if (stat.cnt_zero) code_nxt = ST_UNF;
            else cmd.cnt_clr = 1'b1;
          end
          OP_DUP: begin
            if (stat.cnt_zero) begin
              code_nxt = ST_UNF;
            end else if (stat.cnt_full) begin
              code_nxt = ST_OVF;
            end else begin
              cmd.rd_sel = RD_TOP;
              state_nxt  = S_DUPR;
            end
          end
          default: ;
        endcase
      end
      S_RDA: begin
        cmd.load_a = 1'b1;
        cmd.rd_sel = RD_SECOND;
        state_nxt  = S_RDB;
      end
      S_RDB: begin
        cmd.load_b = 1'b1;
        state_nxt  = (stat.op == OP_SWAP) ? S_SWP1 : S_EXEC;
      end
      S_SWP1: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_TOP;
        cmd.wr_data_sel = WD_B;
        state_nxt       = S_SWP2;
      end
      S_SWP2: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_SECOND;
        cmd.wr_data_sel = WD_A;
        code_nxt        = ST_OK;
        state_nxt       = S_EMIT;
      end
      S_EXEC: begin
        if ((stat.op == OP_DIV || stat.op == OP_MOD) && stat.a_zero) begin
          code_nxt  = ST_DBZ;
          state_nxt = S_EMIT;
        end else begin
          cmd.alu_start = 1'b1;
          if (stat.op == OP_ADD || stat.op == OP_SUB) state_nxt = S_WB;
          else if (stat.op == OP_MUL) state_nxt = S_MUL;
          else state_nxt = S_DIV;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) state_nxt = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_WB;
      end
      S_WB: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_SECOND;
        cmd.wr_data_sel = WD_RES;
        cmd.cnt_dec     = 1'b1;
        code_nxt        = ST_OK;
        state_nxt       = S_EMIT;
      end
      S_PEEK: begin
        cmd.rd_sel = RD_TOP;
        if (stat.slot_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_from_rd = 1'b1;
          cmd.out_last    = 1'b1;
          cmd.out_status  = ST_OK;
          cmd.cnt_dec     = (stat.op == OP_POP);
          state_nxt       = S_IDLE;
        end
      end
      S_DUPR: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_CNT;
        cmd.wr_data_sel = WD_RD;
        cmd.cnt_inc     = 1'b1;
        code_nxt        = ST_OK;
        state_nxt       = S_EMIT;
      end
      S_DUMPW: begin
        cmd.rd_sel = RD_WALK;
        state_nxt  = S_DUMPE;
      end
      S_DUMPE: begin
        cmd.rd_sel = RD_WALK;
        if (stat.slot_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_from_rd = 1'b1;
          cmd.out_last    = stat.walk_last;
          cmd.out_status  = ST_OK;
          cmd.walk_step   = 1'b1;
          state_nxt       = stat.walk_last ? S_IDLE : S_DUMPW;
        end
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = code_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/rpn_dpath.sv */
// Datapath of the RPN calculator: stack memory, count, ALU and result register.
module rpn_dpath #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpn_pkg::rpn_in_t   in_data,
  input  rpn_pkg::rpn_cmd_t  cmd,
  output rpn_pkg::rpn_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output rpn_pkg::rpn_out_t  out_data
);
  import rpn_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [VW-1:0] mem [STACK_DEPTH];
  logic [VW-1:0] rdata_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [VW-1:0] wr_data;

  rpn_in_t       in_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [VW-1:0] a_r, b_r, res_r;
  logic [VW-1:0] ma_r, mb_r;
  logic          neg_r;
  logic [95:0]   acc_r;
  logic [63:0]   quo_r;
  logic [VW-1:0] rem_r;
  logic [5:0]    iter_r;
  logic [AW-1:0] walk_idx_r;
  logic [CW-1:0] walk_rem_r;
  rpn_out_t      out_r;
  logic          out_valid_r;

  logic [VW-1:0] mag_a, mag_b;
  logic [23:0]   mx, my;
  logic [47:0]   pp;
  logic [95:0]   pp_sh;
  logic [VW:0]   shifted, diff;

  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);

  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:    rd_addr = cnt_m1[AW-1:0];
      RD_SECOND: rd_addr = cnt_m2[AW-1:0];
      default:   rd_addr = walk_idx_r;
    endcase
    case (cmd.wr_addr_sel)
      WA_CNT:  wr_addr = cnt_r[AW-1:0];
      WA_TOP:  wr_addr = cnt_m1[AW-1:0];
      default: wr_addr = cnt_m2[AW-1:0];
    endcase
    case (cmd.wr_data_sel)
      WD_IN:   wr_data = in_r.operand;
      WD_RD:   wr_data = rdata_r;
      WD_A:    wr_data = a_r;
      WD_B:    wr_data = b_r;
      default: wr_data = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  // multiplier: one 24x24 partial product per cycle
  assign mag_a = mag48(a_r);
  assign mag_b = mag48(b_r);
  assign mx    = iter_r[0] ? ma_r[47:24] : ma_r[23:0];
  assign my    = iter_r[1] ? mb_r[47:24] : mb_r[23:0];
  assign pp    = mx * my;
  always_comb begin
    case (iter_r[1:0])
      2'd0:    pp_sh = {48'd0, pp};
      2'd3:    pp_sh = {pp, 48'd0};
      default: pp_sh = {24'd0, pp, 24'd0};
    endcase
  end

  // restoring divider, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[63]};
  assign diff    = shifted - {1'b0, ma_r};

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.load_a) a_r <= rdata_r;
    if (cmd.load_b) b_r <= rdata_r;
    if (cmd.alu_start) begin
      ma_r   <= mag_a;
      mb_r   <= mag_b;
      neg_r  <= (in_r.op == OP_MOD) ? b_r[VW-1] : (a_r[VW-1] ^ b_r[VW-1]);
      acc_r  <= '0;
      rem_r  <= '0;
      iter_r <= '0;
      quo_r  <= (in_r.op == OP_DIV) ? {mag_b, 16'd0} : {16'd0, mag_b};
      if (in_r.op == OP_SUB) res_r <= sat49({b_r[VW-1], b_r} - {a_r[VW-1], a_r});
      else res_r <= sat49({b_r[VW-1], b_r} + {a_r[VW-1], a_r});
    end
    if (cmd.mul_step) begin
      acc_r  <= acc_r + pp_sh;
      iter_r <= iter_r + 6'd1;
    end
    if (cmd.div_step) begin
      iter_r <= iter_r + 6'd1;
      if (!diff[VW]) begin
        rem_r <= diff[VW-1:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted[VW-1:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
    if (cmd.res_load) begin
      if (in_r.op == OP_MUL) res_r <= sat_mag(neg_r, acc_r[95:16]);
      else if (in_r.op == OP_DIV) res_r <= sat_mag(neg_r, {16'd0, quo_r});
      else res_r <= neg_r ? (~rem_r + VW'(1)) : rem_r;
    end
    if (cmd.walk_init) begin
      walk_idx_r <= cnt_m1[AW-1:0];
      walk_rem_r <= (int'(cnt_r) > MAX_RESULTS) ? CW'(MAX_RESULTS) : cnt_r;
    end else if (cmd.walk_step) begin
      walk_idx_r <= walk_idx_r - AW'(1);
      walk_rem_r <= walk_rem_r - CW'(1);
    end
    if (cmd.out_load) begin
      out_r.result_value <= cmd.out_from_rd ? rdata_r : '0;
      out_r.has_value    <= cmd.out_from_rd;
      out_r.status       <= cmd.out_status;
      out_r.last         <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + CW'(1);
      else if (cmd.cnt_dec) cnt_r <= cnt_m1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign stat.op        = in_r.op;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.cnt_lt2   = (cnt_r < CW'(2));
  assign stat.cnt_full  = (cnt_r == CW'(STACK_DEPTH));
  assign stat.a_zero    = (a_r == '0);
  assign stat.mul_done  = (iter_r == 6'd3);
  assign stat.div_done  = (iter_r == 6'd63);
  assign stat.walk_last = (walk_rem_r == CW'(1));
  assign stat.slot_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/rpn_stack_calculator.sv */
// Top level of the RPN stack calculator engine.
// One token is taken at a time; in_ready is high only while the engine is idle. Mul is built
// from four 24x24 partial products on one multiplier; div and mod run the one-bit-per-cycle
// restoring divider over 64 quotient bits. Print-all reads one entry at a time through the
// single registered read port of the stack memory. Output beats are held in an output register,
// so the engine can take and work on the next token while the previous beat waits; it stalls
// only when it must load its own beat.
// Values are signed Q31.16; add, sub, mul and div saturate to 48 bits.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rpn_pkg::rpn_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rpn_pkg::rpn_out_t out_data
);
  import rpn_pkg::*;

  rpn_cmd_t  cmd;
  rpn_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/rpn_checker.sv */
// Port-level checks of the RPN calculator, bound to the top level.
`include "assert_macros.svh"

module rpn_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input rpn_pkg::rpn_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input rpn_pkg::rpn_out_t out_data
);
  import rpn_pkg::*;

  `RPN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `RPN_ASSERT(a_noval_zero, clk, rst_n, out_valid && !out_data.has_value |-> out_data.result_value == '0)
  `RPN_ASSERT(a_val_ok, clk, rst_n, out_valid && out_data.has_value |-> out_data.status == ST_OK)
  `RPN_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);

/* tb/tb_rpn_stack_calculator.sv */
// Self-checking testbench of the RPN stack calculator: directed token table, then random tokens.
module tb_rpn_stack_calculator;
  timeunit 1ns;
  timeprecision 1ps;
  import rpn_pkg::*;

  localparam int DEPTH = 32;
  localparam logic signed [47:0] VMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] VMIN = 48'sh8000_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rpn_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rpn_out_t out_data;

  rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [47:0] calc_stack [DEPTH];
  int unsigned calc_depth;
  rpn_out_t beats_due [$];
  int errors = 0;
  bit calm = 1'b0;   // no idling while set

  function automatic logic [47:0] absval(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic signed [47:0] from_mag(input bit neg, input logic [95:0] m);
    if (neg) return (m >= 96'h8000_0000_0000) ? VMIN : 48'(-$signed({1'b0, m[47:0]}));
    return (m > 96'h7FFF_FFFF_FFFF) ? VMAX : m[47:0];
  endfunction

  function automatic logic signed [47:0] clip(input logic signed [48:0] s);
    if (s > 49'sd140737488355327) return VMAX;
    if (s < -49'sd140737488355328) return VMIN;
    return s[47:0];
  endfunction

  function automatic rpn_out_t beat(input bit hv, input logic [47:0] v,
                                    input logic [1:0] st, input bit lst);
    rpn_out_t r;
    r.result_value = hv ? v : '0;
    r.has_value = hv;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  task automatic predict_token(input rpn_in_t t);
    logic signed [47:0] a, b, c;
    logic [95:0] m;
    logic [1:0] st;
    int unsigned n;
    st = ST_OK;
    if (t.op >= OP_ADD && t.op <= OP_MOD) begin
      if (calc_depth < 2) st = ST_UNF;
      else begin
        a = calc_stack[calc_depth-1];
        b = calc_stack[calc_depth-2];
        if ((t.op == OP_DIV || t.op == OP_MOD) && a == 0) st = ST_DBZ;
        else begin
          case (t.op)
            OP_ADD: c = clip({b[47], b} + {a[47], a});
            OP_SUB: c = clip({b[47], b} - {a[47], a});
            OP_MUL: begin
              m = (96'(absval(a)) * 96'(absval(b))) >> 16;
              c = from_mag(a[47] ^ b[47], m);
            end
            OP_DIV: begin
              m = (96'(absval(b)) << 16) / 96'(absval(a));
              c = from_mag(a[47] ^ b[47], m);
            end
            default: begin
              m = 96'(absval(b)) % 96'(absval(a));
              c = b[47] ? 48'(-$signed({1'b0, m[47:0]})) : m[47:0];
            end
          endcase
          calc_depth--;
          calc_stack[calc_depth-1] = c;
        end
      end
      beats_due.push_back(beat(0, 0, st, 1));
      return;
    end
    case (t.op)
      OP_PUSH:
        if (calc_depth >= DEPTH) st = ST_OVF;
        else begin
          calc_stack[calc_depth] = t.operand;
          calc_depth++;
        end
      OP_PEEK, OP_POP:
        if (calc_depth == 0) st = ST_UNF;
        else begin
          a = calc_stack[calc_depth-1];
          if (t.op == OP_POP) calc_depth--;
          beats_due.push_back(beat(1, a, ST_OK, 1));
          return;
        end
      OP_DUMP:
        if (calc_depth == 0) st = ST_UNF;
        else begin
          n = (calc_depth < MAX_RESULTS) ? calc_depth : MAX_RESULTS;
          for (int unsigned i = 0; i < n; i++)
            beats_due.push_back(beat(1, calc_stack[calc_depth-1-i], ST_OK, i + 1 == n));
          return;
        end
      OP_CLEAR:
        if (calc_depth == 0) st = ST_UNF;
        else calc_depth = 0;
      OP_DUP:
        if (calc_depth == 0) st = ST_UNF;
        else if (calc_depth >= DEPTH) st = ST_OVF;
        else begin
          calc_stack[calc_depth] = calc_stack[calc_depth-1];
          calc_depth++;
        end
      OP_SWAP:
        if (calc_depth < 2) st = ST_UNF;
        else begin
          a = calc_stack[calc_depth-1];
          calc_stack[calc_depth-1] = calc_stack[calc_depth-2];
          calc_stack[calc_depth-2] = a;
        end
      default: ;
    endcase
    beats_due.push_back(beat(0, 0, st, 1));
  endtask

  // output checking at the rising edge
  always @(posedge clk) begin
    rpn_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected beat, actual %p", $time, out_data);
        errors++;
      end else begin
        want = beats_due.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 6);

  // called at a falling edge; returns at the falling edge after the token is taken
  task automatic send(input logic [3:0] op, input logic signed [47:0] v);
    rpn_in_t t;
    t.op = op;
    t.operand = v;
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (!calm && $urandom_range(99) < 6) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_token(t);
    @(negedge clk);
  endtask

  // directed table; typed expectations for error cases and unused op codes are checked on top of the predictor
  typedef struct {
    logic [3:0] op;
    logic signed [47:0] v;
    bit typed;
    logic [1:0] st;
  } token_row_t;

  token_row_t dir_rows [] = '{
    '{OP_ADD, 0, 1, ST_UNF}, '{OP_PEEK, 0, 1, ST_UNF}, '{OP_POP, 0, 1, ST_UNF},
    '{OP_DUMP, 0, 1, ST_UNF}, '{OP_CLEAR, 0, 1, ST_UNF}, '{OP_DUP, 0, 1, ST_UNF},
    '{OP_SWAP, 0, 1, ST_UNF}, '{OP_PUSH, VMAX, 0, ST_OK}, '{OP_SUB, 0, 1, ST_UNF},
    '{OP_SWAP, 0, 1, ST_UNF}, '{OP_PUSH, VMAX, 0, ST_OK}, '{OP_ADD, 0, 0, ST_OK},
    '{OP_PUSH, VMIN, 0, ST_OK}, '{OP_MUL, 0, 0, ST_OK}, '{OP_PUSH, 0, 0, ST_OK},
    '{OP_DIV, 0, 1, ST_DBZ}, '{OP_MOD, 0, 1, ST_DBZ}, '{OP_POP, 0, 0, ST_OK},
    '{OP_PUSH, -48'sd1, 0, ST_OK}, '{OP_DIV, 0, 0, ST_OK}, '{OP_PUSH, 48'sh3_0000, 0, ST_OK},
    '{4'd12, 0, 1, ST_OK}, '{4'd15, 0, 1, ST_OK}, '{OP_SWAP, 0, 0, ST_OK},
    '{OP_MOD, 0, 0, ST_OK}
  };

  function automatic logic signed [47:0] rand_val();
    case ($urandom_range(5))
      0: return VMAX;
      1: return VMIN;
      2: return 48'(signed'($urandom_range(255)) - 128) <<< 16;
      3: return 48'(signed'($urandom_range(2000)) - 1000);
      default: return 48'({$urandom(), $urandom()});
    endcase
  endfunction

  initial begin
    logic [3:0] op;
    calc_depth = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        send(dir_rows[i].op, dir_rows[i].v);
        if (beats_due.size() == 0 || beats_due[$].status !== dir_rows[i].st) begin
          $display("%0t: table row %0d expected status %0d", $time, i, dir_rows[i].st);
          errors++;
        end
      end else send(dir_rows[i].op, dir_rows[i].v);
    end
    // fill to full for overflow, dump all 32, then clear
    while (calc_depth < DEPTH) send(OP_PUSH, rand_val());
    send(OP_PUSH, 48'sd5);
    send(OP_DUP, 0);
    send(OP_DUMP, 0);
    send(OP_CLEAR, 0);
    for (int k = 0; k < 60; k++) begin
      calm = (k >= 20 && k < 40);
      if (calc_depth < 2 && $urandom_range(3) != 0) op = OP_PUSH;
      else if ($urandom_range(9) == 0) op = 4'($urandom_range(15));
      else op = 4'($urandom_range(OP_SWAP));
      send(op, rand_val());
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end
endmodule

/* rpn_stack_calculator.f */
+incdir+rtl
rtl/rpn_pkg.sv
rtl/rpn_ctrl.sv
rtl/rpn_dpath.sv
rtl/rpn_stack_calculator.sv
rtl/rpn_checker.sv
tb/tb_rpn_stack_calculator.sv
